// ===== rtl/rsts_pkg.sv =====
// Shared types and constants for the remote time-set sequencer.
`default_nettype none

package rsts_pkg;

    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 8;
    localparam int HOURS_W   = 5;
    localparam int MINSEC_W  = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] HOURS_LIMIT       = 8'd24;
    localparam logic [BYTE_W-1:0] MINSEC_LIMIT      = 8'd60;
    localparam logic [CNT_W-1:0]  WAIT_LIMIT_RESET  = 8'd200;
    localparam logic [CNT_W-1:0]  MAX_RETRIES_RESET = 8'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 2'd1;

    typedef enum logic [1:0] {
        REQ_NONE    = 2'd0,
        REQ_HOURS   = 2'd1,
        REQ_MINUTES = 2'd2,
        REQ_SECONDS = 2'd3
    } send_req_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_FORMAT  = 2'd1,
        EV_TIMEOUT = 2'd2,
        EV_SUCCESS = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        PH_ASK_HOURS    = 3'd0,
        PH_WAIT_HOURS   = 3'd1,
        PH_ASK_MINUTES  = 3'd2,
        PH_WAIT_MINUTES = 3'd3,
        PH_ASK_SECONDS  = 3'd4,
        PH_WAIT_SECONDS = 3'd5
    } phase_t;

    typedef struct packed {
        logic                 mode;
        phase_t               phase;
        logic [CNT_W-1:0]     wait_cnt;
        logic [CNT_W-1:0]     retry_cnt;
        logic [HOURS_W-1:0]   hours;
        logic [MINSEC_W-1:0]  minutes;
        logic [MINSEC_W-1:0]  seconds;
    } seq_state_t;

    typedef struct packed {
        logic              tick;
        logic              start;
        logic              rx_flag;
        logic              rx_nonempty;
        logic [BYTE_W-1:0] rx_byte;
    } tick_in_t;

    typedef struct packed {
        logic [CNT_W-1:0] wait_limit;
        logic [CNT_W-1:0] max_retries;
    } seq_cfg_t;

    typedef struct packed {
        send_req_t send;
        event_t    evt;
    } step_out_t;

endpackage

`default_nettype wire

// ===== rtl/rsts_step.sv =====
// Next-state and result logic for one timer tick of the sequencer.
`default_nettype none

module rsts_step
    import rsts_pkg::*;
(
    input  wire seq_state_t cur,
    input  wire seq_cfg_t   cfg,
    input  wire tick_in_t   item,
    output seq_state_t      nxt,
    output step_out_t       res
);

    logic              in_wait;
    logic              timeout;
    logic              give_up;
    logic              byte_bad;
    logic [BYTE_W-1:0] byte_limit;

    assign in_wait    = (cur.phase == PH_WAIT_HOURS) || (cur.phase == PH_WAIT_MINUTES)
                        || (cur.phase == PH_WAIT_SECONDS);
    assign timeout    = (cur.wait_cnt >= cfg.wait_limit);
    assign give_up    = (cur.retry_cnt >= cfg.max_retries);
    assign byte_limit = (cur.phase == PH_WAIT_HOURS) ? HOURS_LIMIT : MINSEC_LIMIT;
    assign byte_bad   = !item.rx_nonempty || (item.rx_byte >= byte_limit);

    // Next state
    always_comb
    begin
        nxt = cur;
        if (item.tick)
        begin
            if (!cur.mode)
            begin
                if (item.start)
                begin
                    nxt.retry_cnt = '0;
                    nxt.mode      = 1'b1;
                    nxt.phase     = PH_ASK_HOURS;
                end
            end
            else
            begin
                unique case (cur.phase)
                    PH_ASK_HOURS:
                    begin
                        nxt.phase    = PH_WAIT_HOURS;
                        nxt.wait_cnt = '0;
                    end
                    PH_ASK_MINUTES:
                    begin
                        nxt.phase    = PH_WAIT_MINUTES;
                        nxt.wait_cnt = '0;
                    end
                    PH_ASK_SECONDS:
                    begin
                        nxt.phase    = PH_WAIT_SECONDS;
                        nxt.wait_cnt = '0;
                    end
                    PH_WAIT_HOURS, PH_WAIT_MINUTES, PH_WAIT_SECONDS:
                    begin
                        priority if (timeout)
                        begin
                            if (give_up)
                            begin
                                nxt.mode = 1'b0;
                            end
                            else
                            begin
                                nxt.phase     = phase_t'({cur.phase[2:1], 1'b0});
                                nxt.wait_cnt  = '0;
                                nxt.retry_cnt = cur.retry_cnt + 1'b1;
                            end
                        end
                        else if (!item.rx_flag)
                        begin
                            nxt.wait_cnt = cur.wait_cnt + 1'b1;
                        end
                        else if (byte_bad)
                        begin
                            // restart the current request
                            nxt.phase     = phase_t'({cur.phase[2:1], 1'b0});
                            nxt.retry_cnt = '0;
                        end
                        else if (cur.phase == PH_WAIT_HOURS)
                        begin
                            nxt.hours     = item.rx_byte[HOURS_W-1:0];
                            nxt.phase     = PH_ASK_MINUTES;
                            nxt.retry_cnt = '0;
                        end
                        else if (cur.phase == PH_WAIT_MINUTES)
                        begin
                            nxt.minutes   = item.rx_byte[MINSEC_W-1:0];
                            nxt.phase     = PH_ASK_SECONDS;
                            nxt.retry_cnt = '0;
                        end
                        else
                        begin
                            nxt.seconds = item.rx_byte[MINSEC_W-1:0];
                            nxt.mode    = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Result codes
    always_comb
    begin
        res.send = REQ_NONE;
        res.evt  = EV_NONE;
        if (item.tick && cur.mode)
        begin
            unique case (cur.phase)
                PH_ASK_HOURS:   res.send = REQ_HOURS;
                PH_ASK_MINUTES: res.send = REQ_MINUTES;
                PH_ASK_SECONDS: res.send = REQ_SECONDS;
                default:        res.send = REQ_NONE;
            endcase
            if (in_wait)
            begin
                priority if (timeout)
                begin
                    res.evt = give_up ? EV_TIMEOUT : EV_NONE;
                end
                else if (!item.rx_flag)
                begin
                    res.evt = EV_NONE;
                end
                else if (byte_bad)
                begin
                    res.evt = EV_FORMAT;
                end
                else if (cur.phase == PH_WAIT_SECONDS)
                begin
                    res.evt = EV_SUCCESS;
                end
                else
                begin
                    res.evt = EV_NONE;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/remote_time_set_sequencer_top.sv =====
// Top level of the remote time-set sequencer.
// A request's result is registered when the request is accepted.
// Throughput: one request per cycle while out_ready holds; the output register frees in the cycle it is taken.
// The sequencer state updates at the accept edge, so each request sees the last one's state.
// Configuration writes are taken in every cycle (ready held high).
// Reset (rst_n low, async): idle, counters and time cleared, limits 200 and 3, no result.
`default_nettype none

module remote_time_set_sequencer_top
    import rsts_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,

    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CNT_W-1:0]      cfg_data,

    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire                  timer_tick,
    input  wire                  start_request,
    input  wire                  rx_flag,
    input  wire                  rx_nonempty,
    input  wire [BYTE_W-1:0]     rx_last_byte,

    output logic                 out_valid,
    input  wire                  out_ready,
    output logic [1:0]           send_request,
    output logic [1:0]           event_code,
    output logic                 in_update_mode,
    output logic [HOURS_W-1:0]   hours_value,
    output logic [MINSEC_W-1:0]  minutes_value,
    output logic [MINSEC_W-1:0]  seconds_value
);

    seq_cfg_t   cfg_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    tick_in_t   item;
    step_out_t  res;
    logic       in_fire;

    logic                out_valid_reg;
    logic [1:0]          send_reg;
    logic [1:0]          event_reg;
    logic                mode_out_reg;
    logic [HOURS_W-1:0]  hours_out_reg;
    logic [MINSEC_W-1:0] minutes_out_reg;
    logic [MINSEC_W-1:0] seconds_out_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    assign item.tick        = timer_tick;
    assign item.start       = start_request;
    assign item.rx_flag     = rx_flag;
    assign item.rx_nonempty = rx_nonempty;
    assign item.rx_byte     = rx_last_byte;

    rsts_step u_step (
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .item (item),
        .nxt  (state_next),
        .res  (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wait_limit  <= WAIT_LIMIT_RESET;
            cfg_reg.max_retries <= MAX_RETRIES_RESET;
        end
        else if (cfg_valid)
        begin
            // drop writes to unknown indexes
            if (cfg_index == CFG_WAIT_LIMIT)
            begin
                cfg_reg.wait_limit <= cfg_data;
            end
            else if (cfg_index == CFG_MAX_RETRIES)
            begin
                cfg_reg.max_retries <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode      <= 1'b0;
            state_reg.phase     <= PH_ASK_HOURS;
            state_reg.wait_cnt  <= '0;
            state_reg.retry_cnt <= '0;
            state_reg.hours     <= '0;
            state_reg.minutes   <= '0;
            state_reg.seconds   <= '0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            send_reg        <= res.send;
            event_reg       <= res.evt;
            mode_out_reg    <= state_next.mode;
            hours_out_reg   <= state_next.hours;
            minutes_out_reg <= state_next.minutes;
            seconds_out_reg <= state_next.seconds;
        end
    end

    assign out_valid      = out_valid_reg;
    assign send_request   = send_reg;
    assign event_code     = event_reg;
    assign in_update_mode = mode_out_reg;
    assign hours_value    = hours_out_reg;
    assign minutes_value  = minutes_out_reg;
    assign seconds_value  = seconds_out_reg;

endmodule

`default_nettype wire

// ===== rtl/rsts_checker.sv =====
// Port-level checks for the remote time-set sequencer, bound to the top level.
`default_nettype none

module rsts_port_checks
    import rsts_pkg::*;
(
    input wire                 clk,
    input wire                 rst_n,
    input wire                 in_valid,
    input wire                 in_ready,
    input wire                 out_valid,
    input wire                 out_ready,
    input wire [1:0]           send_request,
    input wire [1:0]           event_code,
    input wire                 in_update_mode,
    input wire [HOURS_W-1:0]   hours_value,
    input wire [MINSEC_W-1:0]  minutes_value,
    input wire [MINSEC_W-1:0]  seconds_value
);

    // hold a result until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_code)
            && $stable(send_request))
        else $error("result dropped or changed while stalled");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted request gave no result");

    a_success_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_code == EV_SUCCESS || event_code == EV_TIMEOUT)
            |-> !in_update_mode)
        else $error("sequence end left update mode active");

    a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_request != REQ_NONE |-> in_update_mode && event_code == EV_NONE)
        else $error("send request outside update mode");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hours_value < 5'd24 && minutes_value < 6'd60
            && seconds_value < 6'd60)
        else $error("stored time out of range");

endmodule

bind remote_time_set_sequencer_top rsts_port_checks u_rsts_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .send_request   (send_request),
    .event_code     (event_code),
    .in_update_mode (in_update_mode),
    .hours_value    (hours_value),
    .minutes_value  (minutes_value),
    .seconds_value  (seconds_value)
);

`default_nettype wire

// ===== tb/sv/rsts_checker.sv =====
// Scoreboard for the remote time-set sequencer: predicts each request's result and checks it.
`timescale 1ns / 1ps

module rsts_checker
    import rsts_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,

    input  wire                  cfg_valid,
    input  wire                  cfg_ready,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CNT_W-1:0]      cfg_data,

    input  wire                  in_valid,
    input  wire                  in_ready,
    input  wire                  timer_tick,
    input  wire                  start_request,
    input  wire                  rx_flag,
    input  wire                  rx_nonempty,
    input  wire [BYTE_W-1:0]     rx_last_byte,

    input  wire                  out_valid,
    input  wire                  out_ready,
    input  wire [1:0]            send_request,
    input  wire [1:0]            event_code,
    input  wire                  in_update_mode,
    input  wire [HOURS_W-1:0]    hours_value,
    input  wire [MINSEC_W-1:0]   minutes_value,
    input  wire [MINSEC_W-1:0]   seconds_value,

    output int                   errors,
    output int                   outstanding,
    output int                   n_checked,
    output int                   n_set,
    output int                   n_abort,
    output int                   n_retry
);

    typedef struct packed {
        send_req_t           send;
        event_t              evt;
        logic                mode;
        logic [HOURS_W-1:0]  hours;
        logic [MINSEC_W-1:0] minutes;
        logic [MINSEC_W-1:0] seconds;
    } tick_result_t;

    seq_cfg_t             cfg;
    logic                 mode;
    phase_t               ph;
    logic [CNT_W-1:0]     wait_cnt;
    logic [CNT_W-1:0]     retry_cnt;
    logic [HOURS_W-1:0]   hrs;
    logic [MINSEC_W-1:0]  mins;
    logic [MINSEC_W-1:0]  secs;
    tick_result_t         pending_results[$];

    initial
    begin
        errors = 0;
        outstanding = 0;
        n_checked = 0;
        n_set = 0;
        n_abort = 0;
        n_retry = 0;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= 40)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // One tick in a wait phase: timeout first, then the reply byte.
    function automatic event_t await_reply(input tick_in_t it);
        phase_t            ask_ph;
        logic [BYTE_W-1:0] lim;
        ask_ph = phase_t'(ph - 3'd1);
        lim = (ph == PH_WAIT_HOURS) ? HOURS_LIMIT : MINSEC_LIMIT;
        if (wait_cnt >= cfg.wait_limit)
        begin
            if (retry_cnt >= cfg.max_retries)
            begin
                mode = 1'b0;
                return EV_TIMEOUT;
            end
            ph = ask_ph;
            wait_cnt = '0;
            retry_cnt = retry_cnt + 1'b1;
            return EV_NONE;
        end
        if (!it.rx_flag)
        begin
            wait_cnt = wait_cnt + 1'b1;
            return EV_NONE;
        end
        if (!it.rx_nonempty || it.rx_byte >= lim)
        begin
            ph = ask_ph;
            retry_cnt = '0;
            return EV_FORMAT;
        end
        case (ph)
            PH_WAIT_HOURS:
            begin
                hrs = it.rx_byte[HOURS_W-1:0];
                ph = PH_ASK_MINUTES;
                retry_cnt = '0;
            end
            PH_WAIT_MINUTES:
            begin
                mins = it.rx_byte[MINSEC_W-1:0];
                ph = PH_ASK_SECONDS;
                retry_cnt = '0;
            end
            default:
            begin
                secs = it.rx_byte[MINSEC_W-1:0];
                mode = 1'b0;
                return EV_SUCCESS;
            end
        endcase
        return EV_NONE;
    endfunction

    function automatic tick_result_t step_sequencer(input tick_in_t it);
        tick_result_t r;
        r.send = REQ_NONE;
        r.evt = EV_NONE;
        if (it.tick)
        begin
            if (!mode)
            begin
                if (it.start)
                begin
                    retry_cnt = '0;
                    mode = 1'b1;
                    ph = PH_ASK_HOURS;
                end
            end
            else
            begin
                case (ph)
                    PH_ASK_HOURS:
                    begin
                        r.send = REQ_HOURS;
                        ph = PH_WAIT_HOURS;
                        wait_cnt = '0;
                    end
                    PH_ASK_MINUTES:
                    begin
                        r.send = REQ_MINUTES;
                        ph = PH_WAIT_MINUTES;
                        wait_cnt = '0;
                    end
                    PH_ASK_SECONDS:
                    begin
                        r.send = REQ_SECONDS;
                        ph = PH_WAIT_SECONDS;
                        wait_cnt = '0;
                    end
                    PH_WAIT_HOURS, PH_WAIT_MINUTES, PH_WAIT_SECONDS:
                        r.evt = await_reply(it);
                    default: ;
                endcase
            end
        end
        r.mode = mode;
        r.hours = hrs;
        r.minutes = mins;
        r.seconds = secs;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        tick_in_t     it;
        tick_result_t want;
        if (!rst_n)
        begin
            cfg.wait_limit = WAIT_LIMIT_RESET;
            cfg.max_retries = MAX_RETRIES_RESET;
            mode = 1'b0;
            ph = PH_ASK_HOURS;
            wait_cnt = '0;
            retry_cnt = '0;
            hrs = '0;
            mins = '0;
            secs = '0;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            // Check the result first: it belongs to an earlier request.
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    flag_mismatch("result with nothing expected", 1, 0);
                else
                begin
                    want = pending_results.pop_front();
                    n_checked++;
                    if (send_request != want.send)
                        flag_mismatch("send_request", send_request, want.send);
                    if (event_code != want.evt)
                        flag_mismatch("event_code", event_code, want.evt);
                    if (in_update_mode != want.mode)
                        flag_mismatch("in_update_mode", in_update_mode, want.mode);
                    if (hours_value != want.hours)
                        flag_mismatch("hours_value", hours_value, want.hours);
                    if (minutes_value != want.minutes)
                        flag_mismatch("minutes_value", minutes_value, want.minutes);
                    if (seconds_value != want.seconds)
                        flag_mismatch("seconds_value", seconds_value, want.seconds);
                    case (want.evt)
                        EV_SUCCESS: n_set++;
                        EV_TIMEOUT: n_abort++;
                        EV_FORMAT:  n_retry++;
                        default: ;
                    endcase
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_WAIT_LIMIT)
                    cfg.wait_limit = cfg_data;
                else if (cfg_index == CFG_MAX_RETRIES)
                    cfg.max_retries = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                it.tick = timer_tick;
                it.start = start_request;
                it.rx_flag = rx_flag;
                it.rx_nonempty = rx_nonempty;
                it.rx_byte = rx_last_byte;
                pending_results.push_back(step_sequencer(it));
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

// ===== tb/sv/tb_remote_time_set_sequencer_top.sv =====
// Testbench top for the remote time-set sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_remote_time_set_sequencer_top;
    import rsts_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_WAIT_LIMIT;
    logic [CNT_W-1:0]     cfg_data = '0;

    logic                 in_valid = 1'b0;
    logic                 timer_tick = 1'b0;
    logic                 start_request = 1'b0;
    logic                 rx_flag = 1'b0;
    logic                 rx_nonempty = 1'b0;
    logic [BYTE_W-1:0]    rx_last_byte = '0;

    logic                 out_ready = 1'b0;

    wire                  cfg_ready;
    wire                  in_ready;
    wire                  out_valid;
    wire [1:0]            send_request;
    wire [1:0]            event_code;
    wire                  in_update_mode;
    wire [HOURS_W-1:0]    hours_value;
    wire [MINSEC_W-1:0]   minutes_value;
    wire [MINSEC_W-1:0]   seconds_value;

    int                   errors;
    int                   outstanding;
    int                   n_checked;
    int                   n_set;
    int                   n_abort;
    int                   n_retry;

    int                   ticks_sent = 0;
    int                   cycles = 0;
    int                   stall_left = 0;
    logic                 calm = 1'b0;

    remote_time_set_sequencer_top u_top (.*);

    rsts_checker u_checker (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("remote_time_set_sequencer_top regression: fail");
            $finish;
        end
    end

    // Result side: stall in random bursts; no new burst starts once the run turns calm.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 10);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_tick(input logic t, input logic s, input logic f, input logic n,
                             input logic [BYTE_W-1:0] b);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        timer_tick <= t;
        start_request <= s;
        rx_flag <= f;
        rx_nonempty <= n;
        rx_last_byte <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        ticks_sent++;
    endtask

    task automatic quiet_tick();
        send_tick(1'b1, 1'b0, 1'b0, 1'($urandom_range(0, 1)), 8'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold off until every request has its result, then let the pipe settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limits(input logic [CNT_W-1:0] wait_ticks,
                              input logic [CNT_W-1:0] retries);
        drain();
        write_reg(CFG_WAIT_LIMIT, wait_ticks);
        write_reg(CFG_MAX_RETRIES, retries);
    endtask

    // Start, then ask and answer each field with a valid byte after a short wait.
    task automatic clean_update();
        int f;
        send_tick(1'b1, 1'b1, 1'b0, 1'($urandom_range(0, 1)), 8'($urandom));
        for (f = 0; f < 3; f++)
        begin
            quiet_tick();
            repeat ($urandom_range(0, 3)) quiet_tick();
            if (f == 0)
                send_tick(1'b1, 1'b0, 1'b1, 1'b1,
                          8'($urandom_range(0, int'(HOURS_LIMIT) - 1)));
            else
                send_tick(1'b1, 1'b0, 1'b1, 1'b1,
                          8'($urandom_range(0, int'(MINSEC_LIMIT) - 1)));
        end
    endtask

    task automatic noise_tick(input int flag_pct);
        int                pick;
        logic [BYTE_W-1:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            b = 8'($urandom_range(0, int'(HOURS_LIMIT) - 1));
        else if (pick < 75)
            b = 8'($urandom_range(int'(HOURS_LIMIT), int'(MINSEC_LIMIT) - 1));
        else
            b = 8'($urandom_range(int'(MINSEC_LIMIT), 255));
        send_tick($urandom_range(0, 9) != 0, $urandom_range(0, 6) == 0,
                  $urandom_range(0, 99) < flag_pct, $urandom_range(0, 9) != 0, b);
    endtask

    task automatic random_phase(input int count, input int flag_pct);
        int stop;
        stop = ticks_sent + count;
        while (ticks_sent < stop)
        begin
            if ($urandom_range(0, 9) < 6)
                clean_update();
            else
                repeat ($urandom_range(3, 10)) noise_tick(flag_pct);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk at reset limits.
        send_tick(1'b0, 1'b1, 1'b1, 1'b1, 8'hFF);           // no tick: nothing moves
        send_tick(1'b1, 1'b0, 1'b1, 1'b1, 8'd5);            // idle, no start
        send_tick(1'b1, 1'b1, 1'b0, 1'b0, 8'h00);           // enter update mode
        quiet_tick();                                       // ask hours
        send_tick(1'b1, 1'b0, 1'b1, 1'b0, 8'd7);            // flag with empty buffer
        quiet_tick();
        send_tick(1'b1, 1'b0, 1'b1, 1'b1, HOURS_LIMIT);     // hours out of range
        quiet_tick();
        send_tick(1'b1, 1'b1, 1'b0, 1'b1, 8'd3);            // start while busy
        send_tick(1'b1, 1'b0, 1'b1, 1'b1, HOURS_LIMIT - 1'b1);
        quiet_tick();                                       // ask minutes
        send_tick(1'b1, 1'b0, 1'b1, 1'b1, MINSEC_LIMIT);
        quiet_tick();
        send_tick(1'b1, 1'b0, 1'b1, 1'b1, MINSEC_LIMIT - 1'b1);
        quiet_tick();                                       // ask seconds
        send_tick(1'b0, 1'b0, 1'b1, 1'b1, 8'd1);
        send_tick(1'b1, 1'b0, 1'b1, 1'b1, 8'hFF);
        quiet_tick();
        send_tick(1'b1, 1'b0, 1'b1, 1'b1, 8'd0);            // seconds accepted: done
        send_tick(1'b1, 1'b0, 1'b1, 1'b1, 8'd12);

        // Longest wait with no retries: start, ask, then run the counter out.
        set_limits(8'd255, 8'd0);
        send_tick(1'b1, 1'b1, 1'b0, 1'b0, 8'h00);
        repeat (260) quiet_tick();

        set_limits(8'd1, 8'd0);
        random_phase(30, 25);
        set_limits(8'd0, 8'd2);
        random_phase(15, 30);
        set_limits(8'd3, 8'd255);
        random_phase(35, 35);
        set_limits(8'd200, 8'd3);
        random_phase(25, 50);
        set_limits(8'd2, 8'd1);
        random_phase(20, 35);
        calm <= 1'b1;
        random_phase(20, 35);

        drain();
        $display("checked %0d results: %0d time sets done, %0d timeout aborts, %0d format retries",
                 n_checked, n_set, n_abort, n_retry);
        $display("wait limits 0, 1, 2, 3, 200, 255 against retry limits 0, 1, 2, 3, 255");
        if (errors == 0)
            $display("remote_time_set_sequencer_top regression: pass");
        else
            $display("remote_time_set_sequencer_top regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rsts_pkg.sv
rtl/rsts_step.sv
rtl/remote_time_set_sequencer_top.sv
rtl/rsts_checker.sv
tb/sv/rsts_checker.sv
tb/sv/tb_remote_time_set_sequencer_top.sv
